[src/aes_pkg.sv]
// AES-128 shared package: block types, stage record, S-box tables and
// GF(2^8) helpers. No dependencies.
package aes_pkg;

    typedef logic [127:0] blk_t;
    typedef logic [7:0]   byte_t;

    // one pipeline stage: valid, direction and state
    typedef struct packed {
        logic valid;
        logic op;
        blk_t data;
    } stage_t;

    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    localparam int unsigned NRK = 11;
    localparam int unsigned RK_IDX_W = 4;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam byte_t GF_POLY = 8'h1b;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam byte_t RCON [NRK] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // multiply by x in GF(2^8)
    function automatic byte_t xt(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic byte_t mul2(input byte_t a);
        return xt(a);
    endfunction

    function automatic byte_t mul3(input byte_t a);
        return xt(a) ^ a;
    endfunction

    function automatic byte_t mul9(input byte_t a);
        return xt(xt(xt(a))) ^ a;
    endfunction

    function automatic byte_t mulb(input byte_t a);
        return xt(xt(xt(a))) ^ xt(a) ^ a;
    endfunction

    function automatic byte_t muld(input byte_t a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
    endfunction

    function automatic byte_t mule(input byte_t a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
    endfunction

    // next round key from the previous one
    function automatic blk_t key_step(input blk_t k, input byte_t rc);
        logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

[src/aes_if.sv]
// AES-128 item channels: input and result interfaces with valid/ready.
// Depends on nothing.
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [63:0] block_high;
    logic [63:0] block_low;

    modport source (output valid, opcode, block_high, block_low, input ready);
    modport sink   (input valid, opcode, block_high, block_low, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

[src/aes_key_exp.sv]
// AES-128 key registers and round key sequencer, one round key per cycle.
// Depends on aes_pkg.
module aes_key_exp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [63:0]                cfg_data,
    output logic                       busy,
    output aes_pkg::blk_t              rk [aes_pkg::NRK]
);
    import aes_pkg::*;

    logic [63:0]         key_high_reg;
    logic [63:0]         key_low_reg;
    logic                busy_reg;
    logic [RK_IDX_W-1:0] cnt_reg;
    blk_t                cur_reg;
    blk_t                rk_reg [NRK];
    blk_t                step_next;

    // write key halves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // restart expansion on reset or any key write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (cfg_we)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == RK_IDX_W'(NRK - 1))
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign step_next = key_step(cur_reg, RCON[cnt_reg]);

    // advance one round key per cycle
    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_we)
        begin
            if (cnt_reg == '0)
            begin
                cur_reg    <= {key_high_reg, key_low_reg};
                rk_reg[0]  <= {key_high_reg, key_low_reg};
            end
            else
            begin
                cur_reg         <= step_next;
                rk_reg[cnt_reg] <= step_next;
            end
        end
    end

    assign busy = busy_reg;
    assign rk   = rk_reg;

endmodule

[src/aes_round.sv]
// AES-128 round stage: one forward or inverse round and its pipeline register.
// Depends on aes_pkg.
module aes_round #(
    parameter bit IS_LAST = 1'b0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  aes_pkg::stage_t st_in,
    input  aes_pkg::blk_t   enc_key,
    input  aes_pkg::blk_t   dec_key,
    output aes_pkg::stage_t st_out
);
    import aes_pkg::*;

    logic   valid_reg;
    logic   op_reg;
    blk_t   data_reg;
    blk_t   data_next;

    byte_t s  [16];
    byte_t es [16];
    byte_t eh [16];
    byte_t em [16];
    byte_t ds [16];
    byte_t dh [16];
    byte_t dk [16];
    byte_t dm [16];

    // forward and inverse round on all sixteen bytes
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            s[i] = st_in.data[127 - 8 * i -: 8];
        // forward: SubBytes, ShiftRows, MixColumns
        for (int i = 0; i < 16; i++)
            es[i] = SBOX[s[i]];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                eh[r + 4 * c] = es[r + 4 * ((c + r) & 3)];
        for (int c = 0; c < 4; c++)
        begin
            em[4*c]   = mul2(eh[4*c]) ^ mul3(eh[4*c+1]) ^ eh[4*c+2] ^ eh[4*c+3];
            em[4*c+1] = eh[4*c] ^ mul2(eh[4*c+1]) ^ mul3(eh[4*c+2]) ^ eh[4*c+3];
            em[4*c+2] = eh[4*c] ^ eh[4*c+1] ^ mul2(eh[4*c+2]) ^ mul3(eh[4*c+3]);
            em[4*c+3] = mul3(eh[4*c]) ^ eh[4*c+1] ^ eh[4*c+2] ^ mul2(eh[4*c+3]);
        end
        // inverse: ShiftRows, SubBytes, AddRoundKey, MixColumns
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                dh[r + 4 * c] = s[r + 4 * ((c - r + 4) & 3)];
        for (int i = 0; i < 16; i++)
        begin
            ds[i] = INV_SBOX[dh[i]];
            dk[i] = ds[i] ^ dec_key[127 - 8 * i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            dm[4*c]   = mule(dk[4*c]) ^ mulb(dk[4*c+1]) ^ muld(dk[4*c+2]) ^ mul9(dk[4*c+3]);
            dm[4*c+1] = mul9(dk[4*c]) ^ mule(dk[4*c+1]) ^ mulb(dk[4*c+2]) ^ muld(dk[4*c+3]);
            dm[4*c+2] = muld(dk[4*c]) ^ mul9(dk[4*c+1]) ^ mule(dk[4*c+2]) ^ mulb(dk[4*c+3]);
            dm[4*c+3] = mulb(dk[4*c]) ^ muld(dk[4*c+1]) ^ mul9(dk[4*c+2]) ^ mule(dk[4*c+3]);
        end
        for (int i = 0; i < 16; i++)
        begin
            if (st_in.op == OP_DEC)
                data_next[127 - 8 * i -: 8] = IS_LAST ? dk[i] : dm[i];
            else
                data_next[127 - 8 * i -: 8] =
                    (IS_LAST ? eh[i] : em[i]) ^ enc_key[127 - 8 * i -: 8];
        end
    end

    // advance valid with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= st_in.valid;
    end

    // hold payload on stall
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg   <= st_in.op;
            data_reg <= data_next;
        end
    end

    assign st_out = '{valid: valid_reg, op: op_reg, data: data_reg};

endmodule

[src/aes128_block_cipher.sv]
// AES-128 encrypt/decrypt pipeline, one round per register stage.
// Each item passes through the initial key add register and then ten round registers.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Reset and each key write start a round key expansion; no item is
// accepted during it. Reset loads the all-zero key.
module aes128_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    aes_in_if.sink      in_ch,
    aes_out_if.source   out_ch
);
    import aes_pkg::*;

    logic   key_busy;
    logic   adv;
    logic   accept;
    blk_t   rk [NRK];
    stage_t st [NRK];
    logic   s0_valid_reg;
    logic   s0_op_reg;
    blk_t   s0_data_reg;
    blk_t   s0_data_next;

    aes_key_exp u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (key_busy),
        .rk        (rk)
    );

    // advance whenever the result slot is free or drains
    assign adv         = !st[NRK-1].valid || out_ch.ready;
    assign in_ch.ready = adv && !key_busy && !cfg_we;
    assign accept      = in_ch.valid && in_ch.ready;

    // initial key add
    assign s0_data_next = {in_ch.block_high, in_ch.block_low}
                        ^ ((in_ch.opcode == OP_DEC) ? rk[NRK-1] : rk[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (adv)
            s0_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_op_reg   <= in_ch.opcode;
            s0_data_reg <= s0_data_next;
        end
    end

    assign st[0] = '{valid: s0_valid_reg, op: s0_op_reg, data: s0_data_reg};

    // ten round stages
    for (genvar k = 1; k < NRK; k++)
    begin : g_round
        aes_round #(
            .IS_LAST (k == NRK - 1)
        ) u_round (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .st_in   (st[k-1]),
            .enc_key (rk[k]),
            .dec_key (rk[NRK-1-k]),
            .st_out  (st[k])
        );
    end

    assign out_ch.valid       = st[NRK-1].valid;
    assign out_ch.result_high = st[NRK-1].data[127:64];
    assign out_ch.result_low  = st[NRK-1].data[63:0];

endmodule
